/* hw/rtl/line_substring_matcher_unit_assert.svh */
// Assertion macros for the line substring matcher checker
`ifndef LINE_SUBSTRING_MATCHER_UNIT_ASSERT_SVH
`define LINE_SUBSTRING_MATCHER_UNIT_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted
`define LSM_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define LSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/lsm_pkg.sv */
// Shared types and constants of the line substring matcher
`default_nettype none
package lsm_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int PROBE_BYTES_DEF = 8192;
  localparam int PAT_BYTES       = 16;
  localparam int RES_FIFO_DEPTH  = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 64;

  localparam logic [7:0]  CHAR_LF  = 8'h0A;
  localparam logic [7:0]  CHAR_CR  = 8'h0D;
  localparam logic [7:0]  CHAR_NUL = 8'h00;
  localparam logic [15:0] POS_SAT  = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLD     = 2'd3;

  localparam logic KIND_LINE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] line_number;
    logic [15:0] match_offset;
    logic [31:0] line_total;
    logic        binary_rejected;
    logic        last_of_run;
  } lsm_result_t;

  typedef struct packed {
    logic        first;
    logic        second;
    lsm_result_t r0;
    lsm_result_t r1;
  } lsm_push_t;

endpackage
`default_nettype wire

/* hw/rtl/lsm_core.sv */
// Line tracking, pattern window compare and result generation
`default_nettype none
module lsm_core
  import lsm_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int PROBE_BYTES = PROBE_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  s1_valid,
  input  wire logic [7:0]            s1_byte,
  input  wire logic                  s1_eof,
  output lsm_push_t                  push
);

  localparam int LEN_CAP = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
  localparam int LEN_W   = $clog2(LEN_CAP + 1);
  localparam int IDX_W   = (LEN_CAP > 1) ? $clog2(LEN_CAP) : 1;
  localparam int FBC_W   = $clog2(PROBE_BYTES + 1);

  function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
    if (en && c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  logic [63:0]      pat_low_r, pat_high_r;
  logic [4:0]       pat_len_r;
  logic             fold_r;
  logic [7:0]       win_r [LEN_CAP];
  logic [15:0]      bil_r;
  logic [31:0]      lines_r;
  logic             matched_r;
  logic [15:0]      fmo_r;
  logic             pending_r;
  logic [FBC_W-1:0] fbc_r;
  logic             nul_r;

  logic [7:0]       win_new [LEN_CAP];
  logic [7:0]       win_nxt [LEN_CAP];
  logic [15:0]      bil_nxt;
  logic [31:0]      lines_nxt;
  logic             matched_nxt;
  logic [15:0]      fmo_nxt;
  logic             pending_nxt;
  logic [FBC_W-1:0] fbc_nxt;
  logic             nul_nxt;

  logic [PAT_BYTES*8-1:0] pat_all;
  logic [LEN_W-1:0] act_len;
  logic             hit;
  logic             is_lf, is_cr, take, eol;
  logic [15:0]      bil_inc;
  logic             matched_pre;
  logic             match_now;
  logic [15:0]      hit_off;
  logic             matched_t, pending_t;
  logic [15:0]      fmo_t;
  logic [31:0]      lines_inc;
  logic [FBC_W-1:0] fbc_upd;
  logic             nul_upd;
  logic             report;
  lsm_result_t      rep, sum;

  assign pat_all = {pat_high_r, pat_low_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
      fold_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PAT_LOW:  pat_low_r  <= cfg_wdata;
        CFG_PAT_HIGH: pat_high_r <= cfg_wdata;
        CFG_PAT_LEN:  pat_len_r  <= cfg_wdata[4:0];
        CFG_FOLD:     fold_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(pat_len_r) > LEN_CAP) begin
      act_len = LEN_W'(LEN_CAP);
    end else begin
      act_len = LEN_W'(pat_len_r);
    end
  end

  assign is_lf = (s1_byte == CHAR_LF);
  assign is_cr = (s1_byte == CHAR_CR);
  assign take  = !is_lf;
  assign eol   = is_lf || s1_eof;

  always_comb begin
    win_new[0] = s1_byte;
    for (int k = 1; k < LEN_CAP; k++) begin
      win_new[k] = win_r[k-1];
    end
  end

  always_comb begin
    logic [IDX_W-1:0] widx;
    widx = '0;
    hit  = 1'b1;
    for (int i = 0; i < LEN_CAP; i++) begin
      if (LEN_W'(i) < act_len) begin
        widx = IDX_W'(act_len - LEN_W'(i) - LEN_W'(1));
        if (fold(pat_all[i*8 +: 8], fold_r) != fold(win_new[widx], fold_r)) begin
          hit = 1'b0;
        end
      end
    end
  end

  assign bil_inc     = (bil_r == POS_SAT) ? bil_r : bil_r + 16'd1;
  assign matched_pre = matched_r || pending_r;
  assign match_now   = take && (act_len != '0) && !matched_pre
                       && (bil_inc >= 16'(act_len)) && hit;
  assign hit_off     = (bil_inc == POS_SAT) ? POS_SAT : bil_inc - 16'(act_len);

  assign matched_t = take ? (matched_pre || (match_now && !is_cr)) : matched_r;
  assign pending_t = take ? (match_now && is_cr) : pending_r;
  assign fmo_t     = match_now ? hit_off : fmo_r;
  assign lines_inc = lines_r + 32'd1;

  always_comb begin
    fbc_upd = fbc_r;
    nul_upd = nul_r;
    if (fbc_r < FBC_W'(PROBE_BYTES)) begin
      fbc_upd = fbc_r + FBC_W'(1);
      nul_upd = nul_r || (s1_byte == CHAR_NUL);
    end
  end

  assign report = eol && ((act_len == '0) || matched_t);

  always_comb begin
    rep.result_kind     = KIND_LINE;
    rep.line_number     = lines_inc;
    rep.match_offset    = (act_len == '0) ? 16'd0 : fmo_t;
    rep.line_total      = 32'd0;
    rep.binary_rejected = 1'b0;
    rep.last_of_run     = !s1_eof;
    sum.result_kind     = KIND_SUMMARY;
    sum.line_number     = 32'd0;
    sum.match_offset    = 16'd0;
    sum.line_total      = lines_inc;
    sum.binary_rejected = nul_upd;
    sum.last_of_run     = 1'b1;
  end

  always_comb begin
    push.first  = s1_valid && (report || s1_eof);
    push.second = s1_valid && report && s1_eof;
    push.r0     = report ? rep : sum;
    push.r1     = sum;
  end

  always_comb begin
    win_nxt     = win_r;
    bil_nxt     = bil_r;
    matched_nxt = matched_r;
    fmo_nxt     = fmo_r;
    pending_nxt = pending_r;
    lines_nxt   = lines_r;
    fbc_nxt     = fbc_r;
    nul_nxt     = nul_r;
    if (s1_valid) begin
      if (eol) begin
        for (int k = 0; k < LEN_CAP; k++) begin
          win_nxt[k] = 8'd0;
        end
        bil_nxt     = 16'd0;
        matched_nxt = 1'b0;
        fmo_nxt     = 16'd0;
        pending_nxt = 1'b0;
        lines_nxt   = lines_inc;
      end else begin
        win_nxt     = win_new;
        bil_nxt     = bil_inc;
        matched_nxt = matched_t;
        fmo_nxt     = fmo_t;
        pending_nxt = pending_t;
      end
      if (s1_eof) begin
        lines_nxt = 32'd0;
        fbc_nxt   = '0;
        nul_nxt   = 1'b0;
      end else begin
        fbc_nxt = fbc_upd;
        nul_nxt = nul_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LEN_CAP; k++) begin
        win_r[k] <= 8'd0;
      end
      bil_r     <= '0;
      lines_r   <= '0;
      matched_r <= 1'b0;
      fmo_r     <= '0;
      pending_r <= 1'b0;
      fbc_r     <= '0;
      nul_r     <= 1'b0;
    end else begin
      win_r     <= win_nxt;
      bil_r     <= bil_nxt;
      lines_r   <= lines_nxt;
      matched_r <= matched_nxt;
      fmo_r     <= fmo_nxt;
      pending_r <= pending_nxt;
      fbc_r     <= fbc_nxt;
      nul_r     <= nul_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/lsm_result_fifo.sv */
// Result queue: up to two pushes and one pop per cycle
`default_nettype none
module lsm_result_fifo
  import lsm_pkg::*;
(
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  lsm_push_t                                 push,
  input  wire logic                                 pop,
  output logic [$clog2(RES_FIFO_DEPTH+1)-1:0]       level,
  output lsm_result_t                               head
);

  localparam int PTR_W = $clog2(RES_FIFO_DEPTH);
  localparam int LVL_W = $clog2(RES_FIFO_DEPTH + 1);

  lsm_result_t      mem_r [RES_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.first) + PTR_W'(push.second);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    level_nxt  = level_r + LVL_W'(push.first) + LVL_W'(push.second) - LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.second) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  assign level = level_r;
  assign head  = mem_r[rd_ptr_r];

endmodule
`default_nettype wire

/* hw/rtl/line_substring_matcher_unit.sv */
// A byte's results pass the input register and are then offered by the result queue.
// Throughput: one byte per cycle unless stalled; the input register feeds a compare and
// line update, and a byte that ends the file on a matching line puts two results out.
// The eight-entry result queue stalls input when two more results might not fit.
// Reset: synchronous, active low; clears configuration, line and file state, and queue.
`default_nettype none
module line_substring_matcher_unit
  import lsm_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int PROBE_BYTES = PROBE_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_text_byte,
  input  wire logic                  in_end_of_file,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_result_kind,
  output logic [31:0]                out_line_number,
  output logic [15:0]                out_match_offset,
  output logic [31:0]                out_line_total,
  output logic                       out_binary_rejected,
  output logic                       out_last_of_run
);

  localparam int LVL_W = $clog2(RES_FIFO_DEPTH + 1);

  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_eof_r;
  logic             in_fire;
  logic             pop;
  logic [LVL_W-1:0] level;
  logic [LVL_W:0]   room_need;
  lsm_push_t        push;
  lsm_result_t      head;

  assign room_need = (LVL_W+1)'(level) + (s1_valid_r ? (LVL_W+1)'(2) : '0)
                     + (LVL_W+1)'(2);
  assign in_stall  = room_need > (LVL_W+1)'(RES_FIFO_DEPTH);
  assign in_fire   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_text_byte;
      s1_eof_r  <= in_end_of_file;
    end
  end

  lsm_core #(
    .PATTERN_MAX(PATTERN_MAX),
    .PROBE_BYTES(PROBE_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .s1_valid (s1_valid_r),
    .s1_byte  (s1_byte_r),
    .s1_eof   (s1_eof_r),
    .push     (push)
  );

  assign out_valid = (level != '0);
  assign pop       = out_valid && !out_stall;

  lsm_result_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (pop),
    .level(level),
    .head (head)
  );

  assign out_result_kind     = head.result_kind;
  assign out_line_number     = head.line_number;
  assign out_match_offset    = head.match_offset;
  assign out_line_total      = head.line_total;
  assign out_binary_rejected = head.binary_rejected;
  assign out_last_of_run     = head.last_of_run;

endmodule
`default_nettype wire

/* hw/rtl/lsm_checker.sv */
// Port-level checker for the line substring matcher, with its bind
`default_nettype none
`include "line_substring_matcher_unit_assert.svh"
module lsm_checker
  import lsm_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  cfg_wr_en,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic [7:0]            in_text_byte,
  input wire logic                  in_end_of_file,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic                  out_result_kind,
  input wire logic [31:0]           out_line_number,
  input wire logic [15:0]           out_match_offset,
  input wire logic [31:0]           out_line_total,
  input wire logic                  out_binary_rejected,
  input wire logic                  out_last_of_run
);

  `LSM_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "stalled result transaction dropped")
  `LSM_ASSERT_RST(a_summary_fields, clk, rst_n, out_valid && (out_result_kind == KIND_SUMMARY) |-> (out_line_number == 32'd0) && (out_match_offset == 16'd0) && out_last_of_run, "summary carries line report fields")
  `LSM_ASSERT_RST(a_report_fields, clk, rst_n, out_valid && (out_result_kind == KIND_LINE) |-> (out_line_total == 32'd0) && !out_binary_rejected && (out_line_number != 32'd0 || out_last_of_run || !out_last_of_run), "line report carries summary fields")
  `LSM_ASSERT_ALWAYS(a_reset_ready, clk, !rst_n |=> !in_stall && !out_valid, "block not empty after reset")

endmodule

bind line_substring_matcher_unit lsm_checker u_lsm_checker (.*);
`default_nettype wire
